/* hdl/bdeq_pkg.sv */
// ----------------------------------------------------------------------------
// bdeq_pkg
// shared types and codes of the bounded double-ended queue
// ----------------------------------------------------------------------------
package bdeq_pkg;

    localparam int DATA_W   = 32;
    localparam int OPCODE_W = 3;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    // request opcodes, anything above pop back acts as a query
    localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_QUERY      = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] STS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DATA
    } t_state;

    // memory port enables from the controller
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

    // result bookkeeping handed to the output register
    typedef struct packed {
        logic                load;
        logic [COUNT_W-1:0]  item_count;
        logic                is_empty;
        logic [STATUS_W-1:0] status;
    } t_res_ctl;

endpackage

/* hdl/bdeq_mem.sv */
// ----------------------------------------------------------------------------
// bdeq_mem
// slot store: one write port, two registered read ports
// ----------------------------------------------------------------------------
module bdeq_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                         i_clk,
    input  bdeq_pkg::t_mem_ctl           i_ctl,
    input  logic [AW-1:0]                i_wr_addr,
    input  logic [bdeq_pkg::DATA_W-1:0]  i_wr_data,
    input  logic [AW-1:0]                i_rd_addr_a,
    input  logic [AW-1:0]                i_rd_addr_b,
    output logic [bdeq_pkg::DATA_W-1:0]  o_rd_data_a,
    output logic [bdeq_pkg::DATA_W-1:0]  o_rd_data_b
);

    logic [bdeq_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [bdeq_pkg::DATA_W-1:0] r_rd_a;
    logic [bdeq_pkg::DATA_W-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

/* hdl/bdeq_ctrl.sv */
// ----------------------------------------------------------------------------
// bdeq_ctrl
// head and count update, push writes and end reads
// ----------------------------------------------------------------------------
module bdeq_ctrl #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int CW    = 5
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic [bdeq_pkg::OPCODE_W-1:0]  i_opcode,
    output logic                           o_in_stall,
    input  logic                           i_out_free,
    output bdeq_pkg::t_mem_ctl             o_mem_ctl,
    output logic [AW-1:0]                  o_wr_addr,
    output logic [AW-1:0]                  o_rd_front,
    output logic [AW-1:0]                  o_rd_back,
    output bdeq_pkg::t_res_ctl             o_res
);

    localparam int SW    = CW + 1;
    localparam int CNT_W = bdeq_pkg::COUNT_W;

    bdeq_pkg::t_state                r_state;
    bdeq_pkg::t_state                n_state;
    logic [AW-1:0]                   r_head;
    logic [AW-1:0]                   n_head;
    logic [CW-1:0]                   r_count;
    logic [CW-1:0]                   n_count;
    logic [bdeq_pkg::STATUS_W-1:0]   r_status;
    logic [bdeq_pkg::STATUS_W-1:0]   n_status;

    logic          full;
    logic          empty;
    logic [AW-1:0] head_inc;
    logic [AW-1:0] head_dec;
    logic [AW-1:0] tail_slot;
    logic [AW-1:0] back_slot;

    // sum below twice the depth, one compare and subtract
    function automatic logic [AW-1:0] wrap_sum(input logic [SW-1:0] s);
        if (s >= SW'(DEPTH)) begin
            return AW'(s - SW'(DEPTH));
        end
        return AW'(s);
    endfunction

    assign full      = (r_count == CW'(DEPTH));
    assign empty     = (r_count == '0);
    assign head_inc  = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign head_dec  = (r_head == '0) ? AW'(DEPTH - 1) : r_head - 1'b1;
    assign tail_slot = wrap_sum(SW'(r_head) + SW'(r_count));
    assign back_slot = empty ? r_head : wrap_sum(SW'(r_head) + SW'(r_count) - SW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bdeq_pkg::ST_IDLE;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
    end

    always_comb begin
        n_state          = r_state;
        n_head           = r_head;
        n_count          = r_count;
        n_status         = r_status;
        o_in_stall       = 1'b1;
        o_mem_ctl        = '0;
        o_wr_addr        = tail_slot;
        o_res.load       = 1'b0;
        o_res.item_count = CNT_W'(r_count);
        o_res.is_empty   = empty;
        o_res.status     = r_status;
        unique case (r_state)
            bdeq_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_state  = bdeq_pkg::ST_READ;
                    n_status = bdeq_pkg::STS_DONE;
                    unique case (i_opcode)
                        bdeq_pkg::OP_PUSH_FRONT: begin
                            if (full) begin
                                n_status = bdeq_pkg::STS_FULL;
                            end else begin
                                o_mem_ctl.wr_en = 1'b1;
                                o_wr_addr       = head_dec;
                                n_head          = head_dec;
                                n_count         = r_count + 1'b1;
                            end
                        end
                        bdeq_pkg::OP_PUSH_BACK: begin
                            if (full) begin
                                n_status = bdeq_pkg::STS_FULL;
                            end else begin
                                o_mem_ctl.wr_en = 1'b1;
                                n_count         = r_count + 1'b1;
                            end
                        end
                        bdeq_pkg::OP_POP_FRONT: begin
                            if (empty) begin
                                n_status = bdeq_pkg::STS_EMPTY;
                            end else begin
                                n_head  = head_inc;
                                n_count = r_count - 1'b1;
                            end
                        end
                        bdeq_pkg::OP_POP_BACK: begin
                            if (empty) begin
                                n_status = bdeq_pkg::STS_EMPTY;
                            end else begin
                                n_count = r_count - 1'b1;
                            end
                        end
                        default: begin
                            // query and unused codes leave the state alone
                        end
                    endcase
                end
            end
            bdeq_pkg::ST_READ: begin
                o_mem_ctl.rd_en = 1'b1;
                n_state         = bdeq_pkg::ST_DATA;
            end
            bdeq_pkg::ST_DATA: begin
                if (i_out_free) begin
                    o_res.load = 1'b1;
                    n_state    = bdeq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bdeq_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_rd_front = r_head;
    assign o_rd_back  = back_slot;

endmodule

/* hdl/bounded_double_ended_queue.sv */
// ----------------------------------------------------------------------------
// bounded_double_ended_queue
// fixed-capacity deque of signed 32-bit values in a circular slot memory
// ----------------------------------------------------------------------------
// Each request carries an opcode (push front, push back, pop front, pop back,
// query; unused codes act as a query) and a value for pushes, and returns one
// result: front and back values (0 when empty), the count masked to 5 bits,
// an empty flag and a status (done, push rejected because full, pop ignored
// because empty). A request moves through the controller states in order:
// ST_IDLE accepts it, updates head and count and writes a pushed value,
// ST_READ reads both ends from the slot memory, whose read data is
// registered, and ST_DATA loads the output register once the result side
// is free. The output register lets a new request enter while the previous
// result still waits to be taken. Writes and reads never fall in the same
// cycle, so no forwarding is needed. The slot memory has no clearing pass;
// a slot outside the stored range is read only when the queue is empty.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [bdeq_pkg::OPCODE_W-1:0]        i_opcode,
    input  logic signed [bdeq_pkg::DATA_W-1:0]   i_push_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [bdeq_pkg::DATA_W-1:0]   o_front_value,
    output logic signed [bdeq_pkg::DATA_W-1:0]   o_back_value,
    output logic [bdeq_pkg::COUNT_W-1:0]         o_item_count,
    output logic                                 o_is_empty,
    output logic [bdeq_pkg::STATUS_W-1:0]        o_status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    bdeq_pkg::t_mem_ctl            mem_ctl;
    bdeq_pkg::t_res_ctl            res;
    logic [AW-1:0]                 wr_addr;
    logic [AW-1:0]                 rd_front;
    logic [AW-1:0]                 rd_back;
    logic [bdeq_pkg::DATA_W-1:0]   front_data;
    logic [bdeq_pkg::DATA_W-1:0]   back_data;
    logic                          out_free;

    // output register
    logic                                r_out_valid;
    logic signed [bdeq_pkg::DATA_W-1:0]  r_front;
    logic signed [bdeq_pkg::DATA_W-1:0]  r_back;
    logic [bdeq_pkg::COUNT_W-1:0]        r_count;
    logic                                r_empty;
    logic [bdeq_pkg::STATUS_W-1:0]       r_status;

    // the result slot frees up when empty or taken this cycle
    assign out_free = !r_out_valid || !i_out_stall;

    bdeq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .o_in_stall (o_in_stall),
        .i_out_free (out_free),
        .o_mem_ctl  (mem_ctl),
        .o_wr_addr  (wr_addr),
        .o_rd_front (rd_front),
        .o_rd_back  (rd_back),
        .o_res      (res)
    );

    bdeq_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk       (i_clk),
        .i_ctl       (mem_ctl),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (i_push_value),
        .i_rd_addr_a (rd_front),
        .i_rd_addr_b (rd_back),
        .o_rd_data_a (front_data),
        .o_rd_data_b (back_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // an empty queue reports zero at both ends
    always_ff @(posedge i_clk) begin
        if (res.load) begin
            r_front  <= res.is_empty ? '0 : front_data;
            r_back   <= res.is_empty ? '0 : back_data;
            r_count  <= res.item_count;
            r_empty  <= res.is_empty;
            r_status <= res.status;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_front_value = r_front;
    assign o_back_value  = r_back;
    assign o_item_count  = r_count;
    assign o_is_empty    = r_empty;
    assign o_status      = r_status;

`ifndef SYNTHESIS
    // an accepted request keeps the input side busy for the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again right after a request");

    // a result is loaded only while a request is in progress
    a_load_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.load |-> o_in_stall)
        else $error("result loaded with no request in progress");

    // empty results show zero at both ends
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_empty) |-> (o_front_value == 0 && o_back_value == 0))
        else $error("empty result with nonzero end value");

    // a rejected push never reports an empty queue
    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == bdeq_pkg::STS_FULL) |-> !o_is_empty)
        else $error("full status on an empty queue");
`endif

endmodule
